// ===== sv/matrix_inverse_4x4_defines.svh =====
// ---------------------------------------------------------------------------
// matrix_inverse_4x4_defines.svh
// Assertion macros for the 4x4 matrix inverse block.
// ---------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_4X4_DEFINES_SVH
`define MATRIX_INVERSE_4X4_DEFINES_SVH
`ifndef SYNTH
// Concurrent property, disabled while reset is asserted.
`define MI4_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same, written as antecedent / consequent.
`define MI4_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define MI4_ASSERT(lbl, clk, rst, prop, msg)
`define MI4_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/mi4_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mi4_pkg
// Shared constants, command struct and cofactor term table.
// ---------------------------------------------------------------------------
package mi4_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MUL_W      = ELEM_WIDTH + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int COF_W      = 3 * ELEM_WIDTH + 4;
  localparam int CHUNKS     = (COF_W + ELEM_WIDTH - 1) / ELEM_WIDTH;
  localparam int CH_W       = $clog2(CHUNKS);
  localparam int ACC_W      = 4 * ELEM_WIDTH + 8;
  localparam int DV_W       = ACC_W + ELEM_WIDTH + 2 * FRAC_BITS;
  localparam int IT_W       = $clog2(ELEM_WIDTH);
  localparam int NUM_ELEMS  = 16;
  localparam int TERMS      = 6;

  typedef enum logic [1:0] {
    MUL_XY,
    MUL_ZTLO,
    MUL_ZTHI,
    MUL_ZC
  } mul_sel_t;

  typedef struct packed {
    logic            el_wr;
    logic [3:0]      el_addr;
    logic            ld_x;
    logic            ld_y;
    logic            ld_z;
    logic            z_neg;
    logic            ld_c;
    logic            t_ld;
    logic            mul_en;
    mul_sel_t        mul_sel;
    logic [CH_W-1:0] chunk;
    logic            acc_clr;
    logic            acc_add;
    logic            cof_wr;
    logic [3:0]      cof_addr;
    logic            det_ld;
    logic            div_init;
    logic            div_chk;
    logic            div_step;
    logic            emit;
    logic            last;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] i0;
    logic [3:0] i1;
    logic [3:0] i2;
    logic       neg;
  } term_t;

  // Term j of the 3x3 minor behind adjugate entry k (k = col*4 + row of adj).
  // Element addresses are column-major: {col, row}.
  function automatic term_t cof_term(input logic [3:0] k, input logic [2:0] j);
    term_t      r;
    logic [1:0] rr [0:2];
    logic [1:0] cc [0:2];
    logic [1:0] p0;
    logic [1:0] p1;
    logic [1:0] p2;
    logic       par;
    int         n;
    int         m;
    n = 0;
    m = 0;
    for (int a = 0; a < 4; a++) begin
      if (2'(a) != k[3:2]) begin
        rr[n] = 2'(a);
        n++;
      end
      if (2'(a) != k[1:0]) begin
        cc[m] = 2'(a);
        m++;
      end
    end
    case (j)
      3'd0: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; par = 1'b0; end
      3'd1: begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; par = 1'b0; end
      3'd2: begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; par = 1'b0; end
      3'd3: begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; par = 1'b1; end
      3'd4: begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; par = 1'b1; end
      default: begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; par = 1'b1; end
    endcase
    r.i0  = {cc[p0], rr[0]};
    r.i1  = {cc[p1], rr[1]};
    r.i2  = {cc[p2], rr[2]};
    r.neg = par ^ k[2] ^ k[0];
    return r;
  endfunction

endpackage

// ===== sv/matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
// A matrix takes 16 load beats plus compute; the next one loads only once busy drops.
//   The compute pace is set by the single shared multiplier and the bit-serial divider.
// Reset (rst, synchronous): returns to loading at element 0; stored elements are kept.
// The receiver cannot stall: each result is shown for one cycle under strobe.
// ---------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 fixed-point matrix inverse by cofactors and adjugate.
// ---------------------------------------------------------------------------
`include "matrix_inverse_4x4_defines.svh"

module matrix_inverse_4x4
  import mi4_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [ELEM_WIDTH-1:0] entry_value,
  output logic                         busy,
  output logic                         strobe,
  output logic signed [ELEM_WIDTH-1:0] inverse_value,
  output logic                         singular,
  output logic                         clipped,
  output logic                         final_result
);

  // Flow:
  //   load    - one element per beat (start & !busy), column-major, into the element RAM
  //   cofactor- 16 cofactors, 6 triple-product terms each; each term is x*y, then
  //             z times the low and high halves of that product, added into a wide
  //             accumulator; each cofactor ends with a write-back
  //   det     - first-column expansion: element times cofactor in 4 chunks
  //   divide  - per output, |cof| << 2*FRAC_BITS over |det|, one quotient bit a cycle,
  //             with an overflow check up front for saturation
  // busy drops in the cycle the last result is shown, so the next matrix can start.

  dp_cmd_t cmd;

  mi4_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  mi4_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .entry_value   (entry_value),
    .strobe        (strobe),
    .inverse_value (inverse_value),
    .singular      (singular),
    .clipped       (clipped),
    .final_result  (final_result)
  );

  // Results other than the last one come while the block is still busy.
  `MI4_ASSERT_IMPL(a_mid_busy, clk, rst, strobe && !final_result, busy, "result outside run")
  // A run starts only from an accepted beat.
  `MI4_ASSERT(a_busy_rise, clk, rst, $rose(busy) |-> $past(start), "busy rose without start")
  // Singular results are zero and never flagged clipped.
  `MI4_ASSERT_IMPL(a_sing_zero, clk, rst, strobe && singular, inverse_value == 0 && !clipped, "bad singular beat")

endmodule

// ===== sv/mi4_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mi4_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/mi4_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mi4_ctrl
// Sequencer: load, cofactor, determinant and division phases.
// ---------------------------------------------------------------------------
module mi4_ctrl
  import mi4_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_C_RX, ST_C_RY, ST_C_RZ, ST_C_MXY, ST_C_T, ST_C_ML, ST_C_MH, ST_C_AH, ST_C_WR,
    ST_D_RD, ST_D_LD, ST_D_MUL, ST_D_ADD, ST_D_FIN,
    ST_V_RD, ST_V_INIT, ST_V_CHK, ST_V_IT, ST_V_EMIT
  } state_t;

  state_t          state;
  logic [3:0]      load_count;
  logic [3:0]      k;
  logic [2:0]      j;
  logic [CH_W-1:0] h;
  logic [IT_W-1:0] it;
  term_t           term;

  assign term = cof_term(k, j);
  assign busy = (state != ST_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      k          <= '0;
      j          <= '0;
      h          <= '0;
      it         <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (start) begin
            load_count <= load_count + 4'd1;
            if (load_count == 4'(NUM_ELEMS - 1)) begin
              state <= ST_C_RX;
              k     <= '0;
              j     <= '0;
            end
          end
        end
        ST_C_RX:  state <= ST_C_RY;
        ST_C_RY:  state <= ST_C_RZ;
        ST_C_RZ:  state <= ST_C_MXY;
        ST_C_MXY: state <= ST_C_T;
        ST_C_T:   state <= ST_C_ML;
        ST_C_ML:  state <= ST_C_MH;
        ST_C_MH:  state <= ST_C_AH;
        ST_C_AH: begin
          if (j == 3'(TERMS - 1)) begin
            j     <= '0;
            state <= ST_C_WR;
          end else begin
            j     <= j + 3'd1;
            state <= ST_C_RX;
          end
        end
        ST_C_WR: begin
          if (k == 4'(NUM_ELEMS - 1)) begin
            k     <= '0;
            h     <= '0;
            state <= ST_D_RD;
          end else begin
            k     <= k + 4'd1;
            state <= ST_C_RX;
          end
        end
        ST_D_RD:  state <= ST_D_LD;
        ST_D_LD:  state <= ST_D_MUL;
        ST_D_MUL: state <= ST_D_ADD;
        ST_D_ADD: begin
          if (h == CH_W'(CHUNKS - 1)) begin
            h <= '0;
            if (k == 4'd3) begin
              k     <= '0;
              state <= ST_D_FIN;
            end else begin
              k     <= k + 4'd1;
              state <= ST_D_RD;
            end
          end else begin
            h     <= h + 1'b1;
            state <= ST_D_MUL;
          end
        end
        ST_D_FIN:  state <= ST_V_RD;
        ST_V_RD:   state <= ST_V_INIT;
        ST_V_INIT: state <= ST_V_CHK;
        ST_V_CHK: begin
          it    <= '0;
          state <= ST_V_IT;
        end
        ST_V_IT: begin
          if (it == IT_W'(ELEM_WIDTH - 1)) begin
            state <= ST_V_EMIT;
          end else begin
            it <= it + 1'b1;
          end
        end
        ST_V_EMIT: begin
          if (k == 4'(NUM_ELEMS - 1)) begin
            k     <= '0;
            state <= ST_LOAD;
          end else begin
            k     <= k + 4'd1;
            state <= ST_V_RD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_XY;
    cmd.el_addr  = term.i0;
    cmd.cof_addr = k;
    unique case (state)
      ST_LOAD: begin
        cmd.el_addr = load_count;
        cmd.el_wr   = start;
      end
      ST_C_RX: begin
        cmd.el_addr = term.i0;
        cmd.acc_clr = (j == 3'd0);
      end
      ST_C_RY: begin
        cmd.ld_x    = 1'b1;
        cmd.el_addr = term.i1;
      end
      ST_C_RZ: begin
        cmd.ld_y    = 1'b1;
        cmd.el_addr = term.i2;
      end
      ST_C_MXY: begin
        cmd.ld_z    = 1'b1;
        cmd.z_neg   = term.neg;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_XY;
      end
      ST_C_T: cmd.t_ld = 1'b1;
      ST_C_ML: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ZTLO;
      end
      ST_C_MH: begin
        cmd.acc_add = 1'b1;
        cmd.chunk   = CH_W'(0);
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ZTHI;
      end
      ST_C_AH: begin
        cmd.acc_add = 1'b1;
        cmd.chunk   = CH_W'(1);
      end
      ST_C_WR: cmd.cof_wr = 1'b1;
      ST_D_RD: begin
        cmd.el_addr  = {2'b00, k[1:0]};
        cmd.cof_addr = {k[1:0], 2'b00};
        cmd.acc_clr  = (k == 4'd0);
      end
      ST_D_LD: begin
        cmd.ld_z = 1'b1;
        cmd.ld_c = 1'b1;
      end
      ST_D_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ZC;
        cmd.chunk   = h;
      end
      ST_D_ADD: begin
        cmd.acc_add = 1'b1;
        cmd.chunk   = h;
      end
      ST_D_FIN:  cmd.det_ld   = 1'b1;
      ST_V_RD:   cmd.cof_addr = k;
      ST_V_INIT: cmd.div_init = 1'b1;
      ST_V_CHK:  cmd.div_chk  = 1'b1;
      ST_V_IT:   cmd.div_step = 1'b1;
      ST_V_EMIT: begin
        cmd.emit = 1'b1;
        cmd.last = (k == 4'(NUM_ELEMS - 1));
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/mi4_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mi4_dp
// Datapath: element and cofactor stores, shared multiplier, accumulator,
// restoring divider and saturating output stage.
// ---------------------------------------------------------------------------
module mi4_dp
  import mi4_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  input  logic signed [ELEM_WIDTH-1:0] entry_value,
  output logic                         strobe,
  output logic signed [ELEM_WIDTH-1:0] inverse_value,
  output logic                         singular,
  output logic                         clipped,
  output logic                         final_result
);

  localparam int E = ELEM_WIDTH;

  logic [E-1:0]                el_rdata;
  logic [COF_W-1:0]            cof_rdata;
  logic signed [MUL_W-1:0]     x, y, z, el_ext, op_a, op_b;
  logic [2*E-1:0]              t;
  logic [COF_W-1:0]            c;
  logic [CHUNKS*E-1:0]         c_ext;
  logic [E-1:0]                c_chunk;
  logic signed [PROD_W-1:0]    p;
  logic signed [ACC_W-1:0]     acc, p_ext;
  logic [ACC_W-1:0]            den, den_next;
  logic                        det_neg, det_zero;
  logic [COF_W-1:0]            cof_mag;
  logic [DV_W-1:0]             rem, dd;
  logic [E-1:0]                q, bound, mag;
  logic                        q_neg, big, clip_n, ge;

  mi4_ram #(.WIDTH(E), .DEPTH(NUM_ELEMS)) u_elem_ram (
    .clk     (clk),
    .wr_en   (cmd.el_wr),
    .wr_addr (cmd.el_addr),
    .wr_data (entry_value),
    .rd_addr (cmd.el_addr),
    .rd_data (el_rdata)
  );

  mi4_ram #(.WIDTH(COF_W), .DEPTH(NUM_ELEMS)) u_cof_ram (
    .clk     (clk),
    .wr_en   (cmd.cof_wr),
    .wr_addr (cmd.cof_addr),
    .wr_data (acc[COF_W-1:0]),
    .rd_addr (cmd.cof_addr),
    .rd_data (cof_rdata)
  );

  assign el_ext  = MUL_W'($signed(el_rdata));
  assign c_ext   = {{(CHUNKS*E-COF_W){c[COF_W-1]}}, c};
  assign c_chunk = c_ext[cmd.chunk*E +: E];

  // Low chunks are unsigned, only the top one carries the sign.
  always_comb begin
    op_a = (cmd.mul_sel == MUL_XY) ? x : z;
    case (cmd.mul_sel)
      MUL_XY:   op_b = y;
      MUL_ZTLO: op_b = $signed({1'b0, t[E-1:0]});
      MUL_ZTHI: op_b = $signed({t[2*E-1], t[2*E-1:E]});
      default:  op_b = $signed({(cmd.chunk == CH_W'(CHUNKS - 1)) & c_chunk[E-1], c_chunk});
    endcase
  end

  assign p_ext    = ACC_W'(p);
  assign den_next = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign cof_mag  = cof_rdata[COF_W-1] ? (~cof_rdata + 1'b1) : cof_rdata;
  assign ge       = (rem >= dd);

  always_ff @(posedge clk) begin
    if (cmd.ld_x) x <= el_ext;
    if (cmd.ld_y) y <= el_ext;
    if (cmd.ld_z) z <= cmd.z_neg ? -el_ext : el_ext;
    if (cmd.ld_c) c <= cof_rdata;
    if (cmd.mul_en) p <= op_a * op_b;
    if (cmd.t_ld) t <= p[2*E-1:0];
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + (p_ext <<< (cmd.chunk * E));
    end
    if (cmd.det_ld) begin
      den      <= den_next;
      det_neg  <= acc[ACC_W-1];
      det_zero <= (acc == '0);
    end
    if (cmd.div_init) begin
      rem   <= DV_W'(cof_mag) << (2 * FRAC_BITS);
      q_neg <= cof_rdata[COF_W-1] ^ det_neg;
    end
    if (cmd.div_chk) begin
      big <= (rem >= (DV_W'(den) << E));
      dd  <= DV_W'(den) << (E - 1);
      q   <= '0;
    end
    if (cmd.div_step) begin
      if (ge) rem <= rem - dd;
      q  <= {q[E-2:0], ge};
      dd <= dd >> 1;
    end
  end

  // Output stage: saturate, apply sign, zero on a singular matrix.
  always_comb begin
    bound  = q_neg ? (E'(1) << (E - 1)) : ~(E'(1) << (E - 1));
    clip_n = !det_zero && (big || (q > bound));
    mag    = clip_n ? bound : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      inverse_value <= det_zero ? '0 : (q_neg ? $signed(E'(0) - mag) : $signed(mag));
      singular      <= det_zero;
      clipped       <= clip_n;
      final_result  <= cmd.last;
    end
  end

endmodule

// ===== tb/sv/tb_matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix_inverse_4x4
// Self-checking bench for the 4x4 fixed-point inverse: loads matrices beat by
// beat, predicts the 16 inverse beats with exact wide arithmetic and checks
// every strobed result against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_matrix_inverse_4x4;
  import mi4_pkg::*;

  // Wide enough to hold products of three elements and the shifted numerator.
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [ELEM_WIDTH-1:0] value;
    logic                         sing;
    logic                         clip;
    logic                         last;
  } inv_beat_t;

  localparam int IDLE_PCT   = 37;
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [ELEM_WIDTH-1:0] ONE_Q = 32'sh0001_0000;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic signed [ELEM_WIDTH-1:0] entry_value = '0;
  logic                         busy;
  logic                         strobe;
  logic signed [ELEM_WIDTH-1:0] inverse_value;
  logic                         singular;
  logic                         clipped;
  logic                         final_result;

  // Predictor state: our own copy of the loaded matrix and the load position.
  logic signed [ELEM_WIDTH-1:0] mat_elems [16];
  logic [3:0]                   load_pos = '0;
  inv_beat_t                    inv_pending [$];

  int  mismatches = 0;
  bit  idle_on = 1'b1;
  int  quiet_cycles = 0;

  always #5 clk = ~clk;

  matrix_inverse_4x4 uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .entry_value  (entry_value),
    .busy         (busy),
    .strobe       (strobe),
    .inverse_value(inverse_value),
    .singular     (singular),
    .clipped      (clipped),
    .final_result (final_result)
  );

  // Determinant of the 3x3 minor left after dropping row skip_r and column skip_c.
  function automatic wide_t minor_det(int skip_r, int skip_c);
    wide_t g [9];
    int    n;
    n = 0;
    for (int rr = 0; rr < 4; rr++) begin
      if (rr == skip_r) continue;
      for (int cc = 0; cc < 4; cc++) begin
        if (cc == skip_c) continue;
        g[n] = wide_t'(mat_elems[cc * 4 + rr]);
        n++;
      end
    end
    return g[0] * (g[4] * g[8] - g[5] * g[7])
         - g[1] * (g[3] * g[8] - g[5] * g[6])
         + g[2] * (g[3] * g[7] - g[4] * g[6]);
  endfunction

  // Store one element; the 16th one produces the full inverse prediction.
  task automatic predict_inverse(input logic signed [ELEM_WIDTH-1:0] v);
    wide_t     adj [16];
    wide_t     det;
    wide_t     quot;
    inv_beat_t b;
    mat_elems[load_pos] = v;
    load_pos = load_pos + 4'd1;
    if (load_pos != 4'd0) return;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        adj[c * 4 + r] = minor_det(c, r);
        if ((r + c) % 2 == 1) adj[c * 4 + r] = -adj[c * 4 + r];
      end
    det = '0;
    for (int i = 0; i < 4; i++) det = det + wide_t'(mat_elems[i]) * adj[i * 4];
    for (int k = 0; k < 16; k++) begin
      b.last = (k == 15);
      if (det == 0) begin
        b.value = '0;
        b.sing  = 1'b1;
        b.clip  = 1'b0;
      end else begin
        // Signed division truncates toward zero, as the block does.
        quot   = (adj[k] <<< (2 * FRAC_BITS)) / det;
        b.sing = 1'b0;
        b.clip = 1'b0;
        if (quot > 256'sd2147483647) begin
          quot   = 256'sd2147483647;
          b.clip = 1'b1;
        end else if (quot < -256'sd2147483648) begin
          quot   = -256'sd2147483648;
          b.clip = 1'b1;
        end
        b.value = quot[ELEM_WIDTH-1:0];
      end
      inv_pending.push_back(b);
    end
  endtask

  // Drive one beat; start stays high into the next beat unless idle cycles are drawn.
  task automatic send_entry(input logic signed [ELEM_WIDTH-1:0] v);
    start       <= 1'b1;
    entry_value <= v;
    do @(posedge clk); while (busy);
    predict_inverse(v);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_matrix(input logic signed [ELEM_WIDTH-1:0] m [16]);
    for (int i = 0; i < 16; i++) send_entry(m[i]);
  endtask

  task automatic drain_pending();
    while (inv_pending.size() != 0) @(posedge clk);
  endtask

  // Random element in one of a few value classes.
  function automatic logic signed [ELEM_WIDTH-1:0] rand_elem(int kind);
    case (kind)
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
    endcase
  endfunction

  // Identity: the inverse is the identity, no flags.
  task automatic test_identity();
    logic signed [ELEM_WIDTH-1:0] m [16];
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE_Q : '0;
    send_matrix(m);
  endtask

  // Extremes on the diagonal with two tiny pivots and an extreme off the diagonal: forces saturation both ways.
  task automatic test_extremes();
    logic signed [ELEM_WIDTH-1:0] m [16];
    for (int i = 0; i < 16; i++) m[i] = '0;
    m[0]  = 32'sh7fff_ffff;
    m[5]  = -32'sh8000_0000;
    m[10] = 32'sd1;
    m[15] = -32'sd1;
    m[4]  = 32'sh7fff_ffff;
    send_matrix(m);
  endtask

  // All-zero matrix: the singular case.
  task automatic test_singular();
    logic signed [ELEM_WIDTH-1:0] m [16];
    for (int i = 0; i < 16; i++) m[i] = '0;
    send_matrix(m);
  endtask

  // Random matrices: small, mid and full range elements; some with a boosted diagonal, some singular.
  task automatic test_random(int count);
    logic signed [ELEM_WIDTH-1:0] m [16];
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(4);
      for (int i = 0; i < 16; i++) m[i] = rand_elem(kind % 3);
      if (kind == 3)
        for (int r = 0; r < 4; r++) m[12 + r] = m[4 + r];
      else if (kind == 4)
        for (int r = 0; r < 4; r++) m[r * 4 + r] = m[r * 4 + r] + ONE_Q * 8;
      send_matrix(m);
      // Hold off once mid-run until the whole inverse has come back.
      if (n == count / 2) begin
        start <= 1'b0;
        drain_pending();
      end
    end
  endtask

  // Result checker: one strobed beat per cycle, compared with the oldest prediction.
  always @(posedge clk) begin
    inv_beat_t exp_b;
    if (!rst && strobe) begin
      if (inv_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: value %h", inverse_value);
      end else begin
        exp_b = inv_pending.pop_front();
        if (inverse_value !== exp_b.value || singular !== exp_b.sing ||
            clipped !== exp_b.clip || final_result !== exp_b.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp v=%h s=%b c=%b f=%b got v=%h s=%b c=%b f=%b",
                     exp_b.value, exp_b.sing, exp_b.clip, exp_b.last,
                     inverse_value, singular, clipped, final_result);
        end
      end
    end
  end

  // Watchdog: counts cycles with neither an accepted input nor a result beat.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity();
    test_extremes();
    test_singular();
    test_random(12);
    // Long stretch with no gaps at all.
    idle_on = 1'b0;
    test_random(6);
    idle_on = 1'b1;
    test_random(8);
    start <= 1'b0;
    drain_pending();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && inv_pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
